// ----- hw/rtl/v3a_pkg.sv -----
package v3a_pkg;

   // Operation codes carried by every request.
   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_CROSS = 3'd2,
      OP_DOT   = 3'd3,
      OP_SCALE = 3'd4,
      OP_MAG   = 3'd5,
      OP_UNIT  = 3'd6,
      OP_EQUAL = 3'd7
   } op_type;

endpackage

// ----- hw/rtl/v3a_delay.sv -----
module v3a_delay #(
   parameter int DEPTH = 2,
   parameter int BITS  = 8
) (
   input  logic            clock,
   input  logic            advance,
   input  logic [BITS-1:0] data_in,
   output logic [BITS-1:0] data_out
);

   logic [BITS-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (advance) begin
         tap_ff[0] <= data_in;
         for (int k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign data_out = tap_ff[DEPTH-1];

endmodule

// ----- hw/rtl/v3a_lane.sv -----
module v3a_lane #(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        advance,
   input  v3a_pkg::op_type             op,
   input  logic signed [WORD_BITS-1:0] a_i,
   input  logic signed [WORD_BITS-1:0] b_i,
   input  logic signed [WORD_BITS-1:0] a_j,
   input  logic signed [WORD_BITS-1:0] b_j,
   input  logic signed [WORD_BITS-1:0] a_k,
   input  logic signed [WORD_BITS-1:0] b_k,
   input  logic signed [WORD_BITS-1:0] scale_factor,
   output logic signed [2*WORD_BITS:0] lane_d,
   output logic signed [WORD_BITS:0]   lane_as
);

   localparam int W = WORD_BITS;

   logic signed [W-1:0]   m1a, m1b, m2a, m2b;
   logic signed [2*W-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic signed [W:0]     as1_ff, as1_in;
   logic signed [2*W:0]   d_ff, d_in;
   logic signed [W:0]     as2_ff;

   always_comb begin
      m1a = a_i;
      m1b = a_i;
      m2a = '0;
      m2b = '0;
      case (op)
         v3a_pkg::OP_CROSS: begin
            m1a = a_j;
            m1b = b_k;
            m2a = a_k;
            m2b = b_j;
         end
         v3a_pkg::OP_DOT: begin
            m1b = b_i;
         end
         v3a_pkg::OP_SCALE: begin
            m1b = scale_factor;
         end
         default: begin
         end
      endcase
      p1_in = (2*W)'(m1a) * (2*W)'(m1b);
      p2_in = (2*W)'(m2a) * (2*W)'(m2b);
      if (op == v3a_pkg::OP_SUB) begin
         as1_in = (W+1)'(a_i) - (W+1)'(b_i);
      end else begin
         as1_in = (W+1)'(a_i) + (W+1)'(b_i);
      end
      d_in = (2*W+1)'(p1_ff) - (2*W+1)'(p2_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         as1_ff <= as1_in;
         d_ff   <= d_in;
         as2_ff <= as1_ff;
      end
   end

   assign lane_d  = d_ff;
   assign lane_as = as2_ff;

endmodule

// ----- hw/rtl/v3a_sqrt.sv -----
module v3a_sqrt #(
   parameter int ROOT_BITS = 32,
   parameter int SIDE_BITS = 8
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [2*ROOT_BITS-1:0] rad,
   input  logic [SIDE_BITS-1:0]   side_in,
   output logic [ROOT_BITS-1:0]   root,
   output logic [SIDE_BITS-1:0]   side_out
);

   localparam int R = ROOT_BITS;

   logic [R+1:0]     rem_ff  [R];
   logic [R+1:0]     rem_in  [R];
   logic [R-1:0]     root_ff [R];
   logic [R-1:0]     root_in [R];
   logic [2*R-1:0]   rad_ff  [R];
   logic [2*R-1:0]   rad_in  [R];
   logic [SIDE_BITS-1:0] side_ff [R];
   logic [SIDE_BITS-1:0] side_nx [R];

   // One result bit per stage, restoring digit recurrence.
   for (genvar k = 0; k < R; k++) begin : g_stage
      logic [R+1:0]         rem_prev;
      logic [R-1:0]         root_prev;
      logic [2*R-1:0]       rad_prev;
      logic [R+1:0]         rem_t;
      logic [R+1:0]         trial;
      logic                 ge;

      if (k == 0) begin : g_first
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = rad;
         assign side_nx[k] = side_in;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign side_nx[k] = side_ff[k-1];
      end

      always_comb begin
         rem_t      = {rem_prev[R-1:0], rad_prev[2*R-1 -: 2]};
         trial      = {root_prev, 2'b01};
         ge         = (rem_t >= trial);
         rem_in[k]  = ge ? (rem_t - trial) : rem_t;
         root_in[k] = {root_prev[R-2:0], ge};
         rad_in[k]  = {rad_prev[2*R-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            side_ff[k] <= side_nx[k];
         end
      end
   end

   assign root     = root_ff[R-1];
   assign side_out = side_ff[R-1];

endmodule

// ----- hw/rtl/v3a_div.sv -----
module v3a_div #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [WORD_BITS+FRAC_BITS-1:0] num,
   input  logic [WORD_BITS-1:0]           den,
   output logic [FRAC_BITS:0]             quo
);

   localparam int W = WORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int S = F + 1;

   // The quotient never exceeds 2^F, so only the low F+1 dividend bits need steps.
   logic [W-1:0] rem_ff [S];
   logic [W-1:0] rem_in [S];
   logic [F:0]   low_ff [S];
   logic [F:0]   low_in [S];
   logic [F:0]   quo_ff [S];
   logic [F:0]   quo_in [S];
   logic [W-1:0] den_ff [S];
   logic [W-1:0] den_nx [S];

   for (genvar k = 0; k < S; k++) begin : g_stage
      logic [W-1:0] rem_prev;
      logic [F:0]   low_prev;
      logic [F:0]   quo_prev;
      logic [W:0]   rem_t;
      logic [W:0]   diff;
      logic         ge;

      if (k == 0) begin : g_first
         assign rem_prev  = {1'b0, num[W+F-1:F+1]};
         assign low_prev  = num[F:0];
         assign quo_prev  = '0;
         assign den_nx[k] = den;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign low_prev  = low_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign den_nx[k] = den_ff[k-1];
      end

      always_comb begin
         rem_t     = {rem_prev, low_prev[F]};
         diff      = rem_t - {1'b0, den_nx[k]};
         ge        = (rem_t >= {1'b0, den_nx[k]});
         rem_in[k] = ge ? diff[W-1:0] : rem_t[W-1:0];
         low_in[k] = low_prev << 1;
         quo_in[k] = (F+1)'({quo_prev, ge});
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_nx[k];
         end
      end
   end

   assign quo = quo_ff[S-1];

endmodule

// ----- hw/rtl/vector3_fixed_point_alu_unit.sv -----
// Three-component vector unit in signed fixed point (WORD_BITS-bit words with
// FRAC_BITS fraction bits, Q16.16 by default).
//
// A request carries an opcode, vectors a and b and a scale factor on the req_
// channel; each request gives exactly one response on the rsp_ channel, in
// order. Both channels use valid and ready.
//
// From acceptance to response valid, a request passes the lane multiplier
// stages, the merge stage, the WORD_BITS-stage square root pipeline, the
// FRAC_BITS+1-stage divider pipeline and the output register. Every opcode
// goes through the full pipeline, so a new request is taken every cycle
// while the output register is not stalled.
//
// The whole pipeline moves as one when the output register is empty or being
// taken. When the receiver stalls, the pipeline holds and req_ready drops;
// a response in the output register holds until taken.
// Reset clears the valid bits only; no response is pending after reset.
module vector3_fixed_point_alu_unit #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_opcode,
   input  logic signed [WORD_BITS-1:0] req_a_x,
   input  logic signed [WORD_BITS-1:0] req_a_y,
   input  logic signed [WORD_BITS-1:0] req_a_z,
   input  logic signed [WORD_BITS-1:0] req_b_x,
   input  logic signed [WORD_BITS-1:0] req_b_y,
   input  logic signed [WORD_BITS-1:0] req_b_z,
   input  logic signed [WORD_BITS-1:0] req_scale_factor,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_r_x,
   output logic signed [WORD_BITS-1:0] rsp_r_y,
   output logic signed [WORD_BITS-1:0] rsp_r_z,
   output logic signed [WORD_BITS-1:0] rsp_scalar_result,
   output logic                        rsp_equal_flag,
   output logic                        rsp_saturated,
   output logic                        rsp_zero_magnitude
);

   localparam int W     = WORD_BITS;
   localparam int F     = FRAC_BITS;
   localparam int XW    = 2*W + 3;
   localparam int DEPTH = 3 + W + F + 1;
   localparam int FRONT_BITS = 3 + 1 + 3 + 3*W;
   localparam int SQ_SIDE    = 3*W + W + 1 + 1 + 3 + 3 + 3*W;
   localparam int DIV_SIDE   = 3*W + W + 1 + 1 + 1 + 3 + 3;

   // Clip a wide signed value to a word; the top bit of the result is the flag.
   function automatic logic [W:0] sat_word(input logic [XW-1:0] v);
      logic all_ones;
      logic all_zeros;
      all_ones  = &v[XW-1:W-1];
      all_zeros = ~|v[XW-1:W-1];
      if (all_ones || all_zeros) begin
         return {1'b0, v[W-1:0]};
      end else if (v[XW-1]) begin
         return {1'b1, 1'b1, {(W-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(W-1){1'b1}}};
      end
   endfunction

   // Pipeline control: everything shifts together when the output can move.
   logic             advance;
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign vld_in    = {vld_ff[DEPTH-2:0], req_valid};
   assign rsp_valid_in = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Lanes: one per component, each with its own multipliers.
   v3a_pkg::op_type     op_in;
   logic signed [W-1:0] a_vec [3];
   logic signed [W-1:0] b_vec [3];
   logic signed [2*W:0] lane_d  [3];
   logic signed [W:0]   lane_as [3];

   assign op_in    = v3a_pkg::op_type'(req_opcode);
   assign a_vec[0] = req_a_x;
   assign a_vec[1] = req_a_y;
   assign a_vec[2] = req_a_z;
   assign b_vec[0] = req_b_x;
   assign b_vec[1] = req_b_y;
   assign b_vec[2] = req_b_z;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      v3a_lane #(.WORD_BITS(W)) u_lane (
         .clock        (clock),
         .advance      (advance),
         .op           (op_in),
         .a_i          (a_vec[i]),
         .b_i          (b_vec[i]),
         .a_j          (a_vec[(i+1)%3]),
         .b_j          (b_vec[(i+1)%3]),
         .a_k          (a_vec[(i+2)%3]),
         .b_k          (b_vec[(i+2)%3]),
         .scale_factor (req_scale_factor),
         .lane_d       (lane_d[i]),
         .lane_as      (lane_as[i])
      );
   end

   // Opcode, equality, signs and magnitudes of a travel beside the lanes.
   logic [2:0]      front_neg_in;
   logic [3*W-1:0]  front_abs_in;
   logic            front_eq_in;
   logic [FRONT_BITS-1:0] front_out;
   logic [2:0]      f_op;
   logic            f_eq;
   logic [2:0]      f_neg;
   logic [3*W-1:0]  f_abs;

   always_comb begin
      front_eq_in = (req_a_x == req_b_x) && (req_a_y == req_b_y) && (req_a_z == req_b_z);
      for (int i = 0; i < 3; i++) begin
         front_neg_in[i] = a_vec[i][W-1];
         front_abs_in[i*W +: W] = a_vec[i][W-1] ? (W)'(-a_vec[i]) : a_vec[i];
      end
   end

   v3a_delay #(.DEPTH(2), .BITS(FRONT_BITS)) u_front (
      .clock    (clock),
      .advance  (advance),
      .data_in  ({req_opcode, front_eq_in, front_neg_in, front_abs_in}),
      .data_out (front_out)
   );

   assign {f_op, f_eq, f_neg, f_abs} = front_out;

   // Merge stage: combine the lanes and finish the opcodes that need no root.
   v3a_pkg::op_type f_opt;
   logic [XW-1:0]   dx [3];
   logic [XW-1:0]   ax [3];
   logic [XW-1:0]   sum3;
   logic [W:0]      sw;
   logic [3*W-1:0]  m_r;
   logic [W-1:0]    m_sc;
   logic            m_sat;
   logic            m_eq;

   assign f_opt = v3a_pkg::op_type'(f_op);

   always_comb begin
      sw    = '0;
      m_r   = '0;
      m_sc  = '0;
      m_sat = 1'b0;
      m_eq  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         dx[i] = XW'(lane_d[i]);
         ax[i] = XW'(lane_as[i]);
      end
      sum3 = dx[0] + dx[1] + dx[2];
      case (f_opt)
         v3a_pkg::OP_ADD, v3a_pkg::OP_SUB: begin
            for (int i = 0; i < 3; i++) begin
               sw = sat_word(ax[i]);
               m_r[i*W +: W] = sw[W-1:0];
               m_sat = m_sat | sw[W];
            end
         end
         v3a_pkg::OP_CROSS, v3a_pkg::OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               sw = sat_word(XW'($signed(dx[i]) >>> F));
               m_r[i*W +: W] = sw[W-1:0];
               m_sat = m_sat | sw[W];
            end
         end
         v3a_pkg::OP_DOT: begin
            sw    = sat_word(XW'($signed(sum3) >>> F));
            m_sc  = sw[W-1:0];
            m_sat = sw[W];
         end
         v3a_pkg::OP_EQUAL: begin
            m_eq = f_eq;
         end
         default: begin
         end
      endcase
   end

   logic [SQ_SIDE-1:0] sq_side_ff;
   logic [2*W-1:0]     rad_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_side_ff <= {m_r, m_sc, m_sat, m_eq, f_op, f_neg, f_abs};
         rad_ff     <= sum3[2*W-1:0];
      end
   end

   // Square root of the sum of squares of a.
   logic [W-1:0]       root;
   logic [SQ_SIDE-1:0] sq_out;
   logic [3*W-1:0]     q_r;
   logic [W-1:0]       q_sc;
   logic               q_sat;
   logic               q_eq;
   logic [2:0]         q_op;
   logic [2:0]         q_neg;
   logic [3*W-1:0]     q_abs;

   v3a_sqrt #(.ROOT_BITS(W), .SIDE_BITS(SQ_SIDE)) u_sqrt (
      .clock    (clock),
      .advance  (advance),
      .rad      (rad_ff),
      .side_in  (sq_side_ff),
      .root     (root),
      .side_out (sq_out)
   );

   assign {q_r, q_sc, q_sat, q_eq, q_op, q_neg, q_abs} = sq_out;

   // The magnitude opcode finishes here; a zero root flags the unit opcode.
   logic [W-1:0] g_sc;
   logic         g_sat;
   logic         g_zm;
   logic [W:0]   mw;

   always_comb begin
      g_sc  = q_sc;
      g_sat = q_sat;
      mw    = sat_word({{(XW-W){1'b0}}, root});
      if (v3a_pkg::op_type'(q_op) == v3a_pkg::OP_MAG) begin
         g_sc  = mw[W-1:0];
         g_sat = mw[W];
      end
      g_zm = (v3a_pkg::op_type'(q_op) == v3a_pkg::OP_UNIT) && (root == '0);
   end

   // Unit vector: each component of |a| scaled by 2^F over the root.
   logic [F:0]          quo [3];
   logic [DIV_SIDE-1:0] dv_out;

   for (genvar i = 0; i < 3; i++) begin : g_div
      v3a_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div (
         .clock   (clock),
         .advance (advance),
         .num     ((W+F)'(q_abs[i*W +: W]) << F),
         .den     (root),
         .quo     (quo[i])
      );
   end

   v3a_delay #(.DEPTH(F+1), .BITS(DIV_SIDE)) u_div_side (
      .clock    (clock),
      .advance  (advance),
      .data_in  ({q_r, g_sc, g_sat, q_eq, g_zm, q_op, q_neg}),
      .data_out (dv_out)
   );

   logic [3*W-1:0] d_r;
   logic [W-1:0]   d_sc;
   logic           d_sat;
   logic           d_eq;
   logic           d_zm;
   logic [2:0]     d_op;
   logic [2:0]     d_neg;

   assign {d_r, d_sc, d_sat, d_eq, d_zm, d_op, d_neg} = dv_out;

   // Output register.
   logic [3*W-1:0] out_r_in, out_r_ff;
   logic [W-1:0]   out_sc_ff;
   logic           out_sat_in, out_sat_ff;
   logic           out_eq_ff;
   logic           out_zm_ff;
   logic [XW-1:0]  qv;
   logic [W:0]     qs;

   always_comb begin
      out_r_in   = d_r;
      out_sat_in = d_sat;
      qv         = '0;
      qs         = '0;
      if ((v3a_pkg::op_type'(d_op) == v3a_pkg::OP_UNIT) && !d_zm) begin
         for (int i = 0; i < 3; i++) begin
            qv = {{(XW-F-1){1'b0}}, quo[i]};
            if (d_neg[i]) begin
               qv = -qv;
            end
            qs = sat_word(qv);
            out_r_in[i*W +: W] = qs[W-1:0];
            out_sat_in = out_sat_in | qs[W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_r_ff   <= out_r_in;
         out_sc_ff  <= d_sc;
         out_sat_ff <= out_sat_in;
         out_eq_ff  <= d_eq;
         out_zm_ff  <= d_zm;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_r_x            = out_r_ff[0 +: W];
   assign rsp_r_y            = out_r_ff[W +: W];
   assign rsp_r_z            = out_r_ff[2*W +: W];
   assign rsp_scalar_result  = out_sc_ff;
   assign rsp_equal_flag     = out_eq_ff;
   assign rsp_saturated      = out_sat_ff;
   assign rsp_zero_magnitude = out_zm_ff;

endmodule

// ----- hw/rtl/v3a_checker.sv -----
module v3a_checker #(
   parameter int WORD_BITS = 32
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [WORD_BITS-1:0] rsp_r_x,
   input logic [WORD_BITS-1:0] rsp_r_y,
   input logic [WORD_BITS-1:0] rsp_r_z,
   input logic [WORD_BITS-1:0] rsp_scalar_result,
   input logic                 rsp_equal_flag,
   input logic                 rsp_zero_magnitude
);

   // A stalled response holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_r_x) && $stable(rsp_scalar_result))
      else $error("stalled response changed");

   // No response is pending right after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The pipeline takes requests exactly when the output can move.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output stall");

   // An equality response carries no vector and no scalar.
   a_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_equal_flag |->
         rsp_r_x == '0 && rsp_r_y == '0 && rsp_r_z == '0 && rsp_scalar_result == '0)
      else $error("equality response with data");

   // A zero-magnitude unit response is the zero vector.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_magnitude |->
         rsp_r_x == '0 && rsp_r_y == '0 && rsp_r_z == '0 && !rsp_equal_flag)
      else $error("zero magnitude response with data");

endmodule

bind vector3_fixed_point_alu_unit v3a_checker #(.WORD_BITS(WORD_BITS)) u_v3a_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_r_x            (rsp_r_x),
   .rsp_r_y            (rsp_r_y),
   .rsp_r_z            (rsp_r_z),
   .rsp_scalar_result  (rsp_scalar_result),
   .rsp_equal_flag     (rsp_equal_flag),
   .rsp_zero_magnitude (rsp_zero_magnitude)
);
